>>> sv/selective_repeat_receive_window_core_defines.svh
// assertion macros for the selective-repeat receive window block
// used by the port checker; depends on nothing else
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_CORE_DEFINES_SVH

// clocked assertion with an asynchronous active-low reset
`define SRRW_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block's own clock and reset names
`define SRRW_ASSERT(lbl, prop, msg) `SRRW_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

>>> sv/srrw_pkg.sv
// shared types and constants of the selective-repeat receive window
// no dependencies
`timescale 1ns / 1ps

package srrw_pkg;

	// field widths
	localparam int OFF_W = 31;
	localparam int CNT_W = 11;

	// default geometry
	localparam int WINDOW_SLOTS_DEF  = 32;
	localparam int SEGMENT_BYTES_DEF = 1024;

	typedef logic [OFF_W-1:0] off_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// input mode codes
	localparam logic MODE_ARRIVAL = 1'b0;
	localparam logic MODE_SCAN    = 1'b1;

	// descriptor kind codes
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// one descriptor without its last flag
	typedef struct packed {
		logic kind;
		off_t byte_offset;
		cnt_t byte_count;
	} res_t;

	// sequencer to output stage
	typedef struct packed {
		logic push;
		logic flush;
		res_t res;
	} out_ctrl_t;

endpackage

>>> sv/srrw_intf.sv
// channel interfaces: input items, result descriptors, configuration writes
// depends on srrw_pkg
`timescale 1ns / 1ps

interface srrw_item_if;
	logic              valid;
	logic              ready;
	logic              mode;
	srrw_pkg::off_t    segment_offset;

	modport source (output valid, output mode, output segment_offset, input ready);
	modport sink (input valid, input mode, input segment_offset, output ready);
endinterface

interface srrw_result_if;
	logic              valid;
	logic              ready;
	logic              kind;
	srrw_pkg::off_t    byte_offset;
	srrw_pkg::cnt_t    byte_count;
	logic              last;

	modport source (output valid, output kind, output byte_offset, output byte_count,
		output last, input ready);
	modport sink (input valid, input kind, input byte_offset, input byte_count,
		input last, output ready);
endinterface

interface srrw_cfg_if;
	logic              valid;
	logic              ready;
	srrw_pkg::off_t    file_size;

	modport source (output valid, output file_size, input ready);
	modport sink (input valid, input file_size, output ready);
endinterface

>>> sv/srrw_sub.sv
// shared subtract and compare unit of the window sequencer
// depends on srrw_pkg
`timescale 1ns / 1ps

module srrw_sub (
	input  srrw_pkg::off_t a,
	input  srrw_pkg::off_t b,
	output srrw_pkg::off_t diff,
	output logic           lt
);

	// borrow out of the subtraction flags a below b
	assign {lt, diff} = {1'b0, a} - {1'b0, b};

endmodule

>>> sv/srrw_out.sv
// output stage: holds one descriptor back until the next one or the end
// of the item is known, so the last flag can be set; then an output register
// depends on srrw_pkg, srrw_intf
`timescale 1ns / 1ps

module srrw_out (
	input  logic                clk,
	input  logic                arst_n,
	input  srrw_pkg::out_ctrl_t ctrl,
	output logic                step_ok,
	srrw_result_if.source       result
);

	logic           pend_valid_q;
	srrw_pkg::res_t pend_q;
	logic           out_valid_q;
	srrw_pkg::res_t out_q;
	logic           out_last_q;

	// a step may go ahead when the held descriptor has somewhere to go
	assign step_ok = !pend_valid_q || !out_valid_q || result.ready;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (ctrl.push) begin
			pend_valid_q <= 1'b1;
			if (pend_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end else if (ctrl.flush && pend_valid_q) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload moves
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			pend_q <= ctrl.res;
			if (pend_valid_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (ctrl.flush && pend_valid_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.kind        = out_q.kind;
	assign result.byte_offset = out_q.byte_offset;
	assign result.byte_count  = out_q.byte_count;
	assign result.last        = out_last_q;

endmodule

>>> sv/selective_repeat_receive_window_core.sv
// Selective-repeat receive window core.
// Channels: item (mode, segment_offset) in, result descriptors out, cfg writes
// file_size. All use valid/ready; a transfer happens when both are high.
// An arrival marks its segment in a ring of WINDOW_SLOTS received flags and
// releases every contiguous received segment at the window base (kind 1).
// A scan emits a request (kind 0) for each missing segment in the window.
// The last descriptor of an item carries last = 1; an item may emit none.
// Timing: the block takes one item at a time (item.ready only when idle).
// An arrival finds its slot index by repeated subtraction of the segment
// size on the shared subtractor, once for each segment between the written
// point and the offset, then marks the slot and makes its releases. A scan
// steps through up to WINDOW_SLOTS slots, one slot per cycle while the output
// stage can take a step. Stale or out-of-window arrivals finish with no descriptor.
// One descriptor is held back so the last flag is known; the output register
// lets the result side stall while the sequencer keeps going, and a stalled
// result side holds the sequencer only when both are full.
// Reset clears the ring, the base, the written count and file_size. Config
// writes are taken at any time, meant while idle.
// depends on srrw_pkg, srrw_intf, srrw_sub, srrw_out
`timescale 1ns / 1ps

module selective_repeat_receive_window_core #(
	parameter int WINDOW_SLOTS  = srrw_pkg::WINDOW_SLOTS_DEF,
	parameter int SEGMENT_BYTES = srrw_pkg::SEGMENT_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	srrw_item_if.sink     item,
	srrw_result_if.source result,
	srrw_cfg_if.sink      cfg
);

	localparam int SLOT_W    = $clog2(WINDOW_SLOTS);
	localparam int WIN_BYTES = WINDOW_SLOTS * SEGMENT_BYTES;
	localparam int DIFF_W    = $clog2(WIN_BYTES);
	localparam int DONE_W    = $clog2(WIN_BYTES + 1);

	localparam srrw_pkg::off_t    SEG_C     = srrw_pkg::off_t'(SEGMENT_BYTES);
	localparam srrw_pkg::off_t    WIN_C     = srrw_pkg::off_t'(WIN_BYTES);
	localparam logic [SLOT_W:0]   SLOTS_C   = (SLOT_W + 1)'(WINDOW_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
	localparam logic [SLOT_W-1:0] ONE_SLOT  = SLOT_W'(1);
	localparam logic [DONE_W-1:0] SEG_D     = DONE_W'(SEGMENT_BYTES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARR_CHK,
		ST_ARR_DIV,
		ST_DRAIN,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                   state_q;
	srrw_pkg::off_t           fs_q;
	srrw_pkg::off_t           bw_q;
	logic [SLOT_W-1:0]        base_q;
	logic [WINDOW_SLOTS-1:0]  map_q;

	srrw_pkg::off_t           off_q;
	logic [DIFF_W-1:0]        diff_q;
	logic [SLOT_W-1:0]        idx_q;
	srrw_pkg::off_t           rem_q;
	logic [DONE_W-1:0]        done_q;
	logic [SLOT_W-1:0]        ptr_q;
	logic [SLOT_W-1:0]        cnt_i_q;

	srrw_pkg::off_t           sub_a;
	srrw_pkg::off_t           sub_b;
	srrw_pkg::off_t           sub_diff;
	logic                     sub_lt;
	logic                     left_zero;
	srrw_pkg::off_t           seg_cnt;
	logic [SLOT_W-1:0]        rd_addr;
	logic                     map_bit;
	logic [SLOT_W:0]          slot_sum;
	logic [SLOT_W-1:0]        slot;
	logic [SLOT_W-1:0]        base_inc;
	logic [SLOT_W-1:0]        ptr_inc;
	logic                     step_ok;
	srrw_pkg::out_ctrl_t      octrl;

	// operand select for the shared subtractor
	always_comb begin
		sub_a = fs_q;
		sub_b = bw_q;
		unique case (state_q)
			ST_ARR_CHK: begin
				sub_a = off_q;
				sub_b = bw_q;
			end
			ST_ARR_DIV: begin
				sub_a = srrw_pkg::off_t'(diff_q);
				sub_b = SEG_C;
			end
			ST_SCAN: begin
				sub_a = rem_q;
				sub_b = srrw_pkg::off_t'(done_q);
			end
			default: begin
				sub_a = fs_q;
				sub_b = bw_q;
			end
		endcase
	end

	srrw_sub u_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff),
		.lt   (sub_lt)
	);

	// remaining bytes, saturated, and the size of the segment they start
	assign left_zero = sub_lt || (sub_diff == '0);
	assign seg_cnt   = (sub_diff < SEG_C) ? sub_diff : SEG_C;

	// single read port into the received marks
	assign rd_addr = (state_q == ST_SCAN) ? ptr_q : base_q;
	assign map_bit = map_q[rd_addr];

	// ring arithmetic
	assign slot_sum = {1'b0, base_q} + {1'b0, idx_q};
	assign slot     = (slot_sum >= SLOTS_C) ? SLOT_W'(slot_sum - SLOTS_C) : slot_sum[SLOT_W-1:0];
	assign base_inc = (base_q == LAST_SLOT) ? '0 : base_q + ONE_SLOT;
	assign ptr_inc  = (ptr_q == LAST_SLOT) ? '0 : ptr_q + ONE_SLOT;

	// descriptor to the output stage
	always_comb begin
		octrl.push            = 1'b0;
		octrl.flush           = 1'b0;
		octrl.res.kind        = srrw_pkg::KIND_REQUEST;
		octrl.res.byte_offset = bw_q + srrw_pkg::off_t'(done_q);
		octrl.res.byte_count  = seg_cnt[srrw_pkg::CNT_W-1:0];
		unique case (state_q)
			ST_DRAIN: begin
				octrl.res.kind        = srrw_pkg::KIND_RELEASE;
				octrl.res.byte_offset = bw_q;
				octrl.push            = step_ok && map_bit && !left_zero;
			end
			ST_SCAN: begin
				octrl.push = step_ok && !map_bit && !left_zero;
			end
			ST_FINISH: begin
				octrl.flush = step_ok;
			end
			default: begin
				octrl.push = 1'b0;
			end
		endcase
	end

	srrw_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (octrl),
		.step_ok (step_ok),
		.result  (result)
	);

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fs_q    <= '0;
			bw_q    <= '0;
			base_q  <= '0;
			map_q   <= '0;
		end else begin
			if (cfg.valid) begin
				fs_q <= cfg.file_size;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= (item.mode == srrw_pkg::MODE_SCAN) ? ST_SCAN_INIT : ST_ARR_CHK;
					end
				end
				ST_ARR_CHK: begin
					// stale or beyond the window: nothing to do
					if (sub_lt || sub_diff >= WIN_C) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_ARR_DIV;
					end
				end
				ST_ARR_DIV: begin
					if (sub_lt) begin
						map_q[slot] <= 1'b1;
						state_q     <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (step_ok) begin
						if (left_zero || !map_bit) begin
							state_q <= ST_FINISH;
						end else begin
							bw_q          <= bw_q + seg_cnt;
							map_q[base_q] <= 1'b0;
							base_q        <= base_inc;
						end
					end
				end
				ST_SCAN_INIT: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (step_ok && (left_zero || cnt_i_q == LAST_SLOT)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (step_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				off_q <= item.segment_offset;
			end
			ST_ARR_CHK: begin
				diff_q <= sub_diff[DIFF_W-1:0];
				idx_q  <= '0;
			end
			ST_ARR_DIV: begin
				if (!sub_lt) begin
					diff_q <= sub_diff[DIFF_W-1:0];
					idx_q  <= idx_q + ONE_SLOT;
				end
			end
			ST_SCAN_INIT: begin
				rem_q   <= sub_lt ? '0 : sub_diff;
				done_q  <= '0;
				ptr_q   <= base_q;
				cnt_i_q <= '0;
			end
			ST_SCAN: begin
				if (step_ok) begin
					done_q  <= done_q + SEG_D;
					ptr_q   <= ptr_inc;
					cnt_i_q <= cnt_i_q + ONE_SLOT;
				end
			end
			default: begin
				off_q <= off_q;
			end
		endcase
	end

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;

endmodule

>>> sv/srrw_checker.sv
// port checker for the receive window core, bound to the top level
// depends on srrw_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "selective_repeat_receive_window_core_defines.svh"

module srrw_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_ready,
	input logic           result_valid,
	input logic           result_ready,
	input logic           result_last,
	input srrw_pkg::off_t result_byte_offset,
	input srrw_pkg::cnt_t result_byte_count
);

	// one item at a time: busy right after an input transfer
	`SRRW_ASSERT(a_busy_after_accept, item_valid && item_ready |=> !item_ready, "ready after accept")

	// when idle, anything still waiting at the output closes its item
	`SRRW_ASSERT(a_idle_only_last, item_ready && result_valid |-> result_last, "idle with open item")

	// stalled descriptor stays offered
	`SRRW_ASSERT(a_valid_held, result_valid && !result_ready |=> result_valid, "result valid dropped")

	// stalled descriptor keeps its payload
	`SRRW_ASSERT(a_payload_held, result_valid && !result_ready |=> $stable(result_byte_offset) && $stable(result_byte_count), "result payload changed")

endmodule

bind selective_repeat_receive_window_core srrw_checker u_srrw_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.item_valid         (item.valid),
	.item_ready         (item.ready),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.result_last        (result.last),
	.result_byte_offset (result.byte_offset),
	.result_byte_count  (result.byte_count)
);

>>> tb/testbench.sv
// testbench for the selective-repeat receive window core: drives arrival and scan items,
// predicts the release and request descriptors and checks them as they come out
// depends on srrw_pkg, srrw_intf and selective_repeat_receive_window_core
`timescale 1ns / 1ps

module testbench;

	localparam int SLOTS = srrw_pkg::WINDOW_SLOTS_DEF;
	localparam int SEG_BYTES = srrw_pkg::SEGMENT_BYTES_DEF;
	// longest item: offset search, one drain over the whole ring, pipeline slack
	localparam int DRAIN_PAD = 3 + 2 * SLOTS + 32;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 100;

	typedef bit [srrw_pkg::OFF_W-1:0] uoff_t;

	typedef struct {
		logic mode;
		srrw_pkg::off_t offset;
	} seg_item_t;

	typedef struct {
		srrw_pkg::res_t res;
		logic last;
	} desc_t;

	logic clk;
	logic arst_n;

	srrw_item_if item_bus();
	srrw_result_if result_bus();
	srrw_cfg_if cfg_bus();

	selective_repeat_receive_window_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// window state as the block should hold it
	bit ring_marks [SLOTS];
	bit [$clog2(SLOTS)-1:0] ring_head;
	uoff_t released_bytes;
	uoff_t file_bytes;

	desc_t due_descs[$];
	seg_item_t item_backlog[$];
	int unsigned items_queued;
	int unsigned items_taken;
	int unsigned cfg_taken;
	int unsigned fails;
	bit item_taken;

	// sender and receiver pacing
	int unsigned burst_left;
	int unsigned gap_left;
	seg_item_t next_item;
	int unsigned holds_asked;
	int unsigned holds_served;
	int unsigned hold_left;
	int unsigned stall_phase;
	int unsigned stall_style;
	bit [31:0] stall_mask;

	// stimulus planning
	longint unsigned plan_bytes;
	srrw_pkg::off_t late_offs[$];

	always #5 clk = ~clk;

	function automatic longint unsigned bytes_left();
		return (file_bytes > released_bytes) ? longint'(file_bytes - released_bytes) : 0;
	endfunction

	// expected descriptors for one accepted item
	function automatic void step_window(logic mode, srrw_pkg::off_t seg_off);
		desc_t batch[$];
		desc_t d;
		longint unsigned left;
		longint unsigned cnt;
		longint unsigned slot_idx;
		longint unsigned done;
		if (mode == srrw_pkg::MODE_ARRIVAL) begin
			if (uoff_t'(seg_off) >= released_bytes) begin
				slot_idx = (longint'(seg_off) - longint'(released_bytes)) / SEG_BYTES;
				if (slot_idx < SLOTS) begin
					ring_marks[(ring_head + slot_idx) % SLOTS] = 1'b1;
					// release contiguous received segments at the base
					for (int i = 0; i < SLOTS; i++) begin
						left = bytes_left();
						if (!ring_marks[ring_head] || left == 0)
							break;
						cnt = (left < SEG_BYTES) ? left : SEG_BYTES;
						d.res.kind = srrw_pkg::KIND_RELEASE;
						d.res.byte_offset = released_bytes;
						d.res.byte_count = srrw_pkg::cnt_t'(cnt);
						d.last = 1'b0;
						batch.push_back(d);
						released_bytes = uoff_t'(released_bytes + cnt);
						ring_marks[ring_head] = 1'b0;
						ring_head++;
					end
				end
			end
		end else begin
			// request every missing segment inside the window
			left = bytes_left();
			for (int i = 0; i < SLOTS; i++) begin
				done = longint'(i) * SEG_BYTES;
				if (done >= left)
					break;
				if (!ring_marks[(ring_head + i) % SLOTS]) begin
					cnt = (left - done < SEG_BYTES) ? left - done : SEG_BYTES;
					d.res.kind = srrw_pkg::KIND_REQUEST;
					d.res.byte_offset = srrw_pkg::off_t'(released_bytes + done);
					d.res.byte_count = srrw_pkg::cnt_t'(cnt);
					d.last = 1'b0;
					batch.push_back(d);
				end
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			due_descs.push_back(batch[k]);
	endfunction

	// sender: bursts with random gaps, valid held until the transfer
	always @(negedge clk) begin
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
			item_bus.mode <= srrw_pkg::MODE_ARRIVAL;
			item_bus.segment_offset <= '0;
		end else if (!item_bus.valid || item_taken) begin
			item_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				item_bus.valid <= 1'b0;
			end else if (item_backlog.size() > 0) begin
				next_item = item_backlog.pop_front();
				item_bus.valid <= 1'b1;
				item_bus.mode <= next_item.mode;
				item_bus.segment_offset <= next_item.offset;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				item_bus.valid <= 1'b0;
			end
		end
	end

	// item and register transfers feed the prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				file_bytes = cfg_bus.file_size;
				cfg_taken++;
			end
			if (item_bus.valid && item_bus.ready) begin
				step_window(item_bus.mode, item_bus.segment_offset);
				item_taken = 1'b1;
				items_taken++;
			end
		end
	end

	// receiver: long hold on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_bus.ready <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
			result_bus.ready <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				stall_style = $urandom_range(0, 2);
				stall_mask = $urandom;
				stall_phase = 24;
			end
			stall_phase--;
			case (stall_style)
				0: begin
					result_bus.ready <= 1'b1;
				end
				1: begin
					result_bus.ready <= stall_mask[stall_phase];
				end
				default: begin
					result_bus.ready <= ($urandom_range(0, 7) != 0);
				end
			endcase
		end
	end

	// descriptor check against the oldest expectation
	always @(posedge clk) begin
		desc_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (due_descs.size() == 0) begin
				fails++;
				if (fails <= MAX_REPORTS)
					$display("%0t: expected none, actual kind %0d offset %0d count %0d last %0d",
						$time, result_bus.kind, result_bus.byte_offset,
						result_bus.byte_count, result_bus.last);
			end else begin
				want = due_descs.pop_front();
				if (result_bus.kind !== want.res.kind
						|| result_bus.byte_offset !== want.res.byte_offset
						|| result_bus.byte_count !== want.res.byte_count
						|| result_bus.last !== want.last) begin
					fails++;
					if (fails <= MAX_REPORTS)
						$display("%0t: expected kind %0d offset %0d count %0d last %0d, %s %0d %0d %0d %0d",
							$time, want.res.kind, want.res.byte_offset, want.res.byte_count,
							want.last, "actual", result_bus.kind, result_bus.byte_offset,
							result_bus.byte_count, result_bus.last);
				end
			end
		end
	end

	task automatic add_item(logic mode, srrw_pkg::off_t offset);
		seg_item_t it;
		it.mode = mode;
		it.offset = offset;
		item_backlog.push_back(it);
		items_queued++;
	endtask

	// wait until the block is idle with nothing outstanding
	task automatic settle_window();
		while (items_taken != items_queued || due_descs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_file_size(uoff_t value);
		int unsigned seen;
		@(negedge clk);
		seen = cfg_taken;
		cfg_bus.valid <= 1'b1;
		cfg_bus.file_size <= value;
		do @(negedge clk); while (cfg_taken == seen);
		cfg_bus.valid <= 1'b0;
	endtask

	// one run of consecutive segments in shuffled order, with noise mixed in
	task automatic queue_round();
		int segs[$];
		srrw_pkg::off_t carried[$];
		int n;
		int b;
		int tmp;
		int pick;
		srrw_pkg::off_t off;
		if (plan_bytes < released_bytes)
			plan_bytes = released_bytes;
		n = $urandom_range(1, 10);
		carried = late_offs;
		late_offs.delete();
		for (int k = 0; k < n; k++)
			segs.push_back(k);
		for (int a = n - 1; a > 0; a--) begin
			b = $urandom_range(0, a);
			tmp = segs[a];
			segs[a] = segs[b];
			segs[b] = tmp;
		end
		foreach (segs[k]) begin
			pick = $urandom_range(0, 99);
			if (pick < 12)
				add_item(srrw_pkg::MODE_SCAN, srrw_pkg::off_t'($urandom));
			else if (pick < 18)
				add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'($urandom));
			else if (pick < 23 && released_bytes > 0)
				add_item(srrw_pkg::MODE_ARRIVAL,
					srrw_pkg::off_t'($urandom_range(0, released_bytes - 1)));
			else if (pick < 27)
				add_item(srrw_pkg::MODE_ARRIVAL,
					srrw_pkg::off_t'(plan_bytes + $urandom_range(28, 40) * SEG_BYTES));
			off = srrw_pkg::off_t'(plan_bytes + segs[k] * SEG_BYTES
				+ (($urandom_range(0, 3) == 0) ? $urandom_range(0, SEG_BYTES - 1) : 0));
			// some segments come late, leaving a gap for a while
			if ($urandom_range(0, 9) == 0)
				late_offs.push_back(off);
			else
				add_item(srrw_pkg::MODE_ARRIVAL, off);
			if ($urandom_range(0, 15) == 0)
				add_item(srrw_pkg::MODE_ARRIVAL, off);
		end
		foreach (carried[k])
			add_item(srrw_pkg::MODE_ARRIVAL, carried[k]);
		plan_bytes += n * SEG_BYTES;
	endtask

	task automatic queue_random(int unsigned count);
		int unsigned stop_at;
		stop_at = items_queued + count;
		while (items_queued < stop_at) begin
			while (item_backlog.size() > 2)
				@(negedge clk);
			queue_round();
		end
		foreach (late_offs[k])
			add_item(srrw_pkg::MODE_ARRIVAL, late_offs[k]);
		late_offs.delete();
	endtask

	initial begin
		int unsigned waited;
		clk = 1'b0;
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.mode = srrw_pkg::MODE_ARRIVAL;
		item_bus.segment_offset = '0;
		result_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.file_size = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty file after reset: nothing comes out, the mark stays
		add_item(srrw_pkg::MODE_SCAN, '0);
		add_item(srrw_pkg::MODE_ARRIVAL, '0);
		settle_window();

		// short file with a partial last segment
		write_file_size(uoff_t'(10 * SEG_BYTES + 300));
		add_item(srrw_pkg::MODE_SCAN, '0);
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(3 * SEG_BYTES + 5));
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(2 * SEG_BYTES));
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(SEG_BYTES));
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(3000));
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(5 * SEG_BYTES));
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(5 * SEG_BYTES));
		add_item(srrw_pkg::MODE_ARRIVAL,
			srrw_pkg::off_t'(4 * SEG_BYTES + (SLOTS - 1) * SEG_BYTES));
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(4 * SEG_BYTES + SLOTS * SEG_BYTES));
		add_item(srrw_pkg::MODE_ARRIVAL, '1);
		add_item(srrw_pkg::MODE_SCAN, '1);
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(4 * SEG_BYTES));
		for (int s = 10; s >= 6; s--)
			add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(s * SEG_BYTES));
		add_item(srrw_pkg::MODE_SCAN, '0);
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(10 * SEG_BYTES + 300));
		settle_window();

		// largest file; the receiver holds off first so the block backs up
		write_file_size('1);
		holds_asked++;
		repeat (4) add_item(srrw_pkg::MODE_SCAN, '0);
		plan_bytes = released_bytes;
		queue_random(40);
		settle_window();

		// file size below the released count
		write_file_size(uoff_t'(100));
		add_item(srrw_pkg::MODE_SCAN, '0);
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(released_bytes));
		settle_window();

		// file that ends during the random part
		write_file_size(uoff_t'(released_bytes + 20 * SEG_BYTES + $urandom_range(1, SEG_BYTES - 1)));
		plan_bytes = released_bytes;
		queue_random(30);
		settle_window();

		// one byte left
		write_file_size(uoff_t'(released_bytes + 1));
		add_item(srrw_pkg::MODE_SCAN, '0);
		add_item(srrw_pkg::MODE_ARRIVAL, srrw_pkg::off_t'(released_bytes));
		add_item(srrw_pkg::MODE_SCAN, '0);

		// wind down
		while (items_taken != items_queued)
			@(posedge clk);
		waited = 0;
		while (due_descs.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_PAD) @(posedge clk);
		if (due_descs.size() != 0) begin
			fails++;
			$display("%0t: %0d expected descriptors never came out", $time, due_descs.size());
		end
		if (fails == 0)
			$display("selective_repeat_receive_window_core: match");
		else
			$display("selective_repeat_receive_window_core: mismatch");
		$finish;
	end

	// run limit
	initial begin
		#3000000;
		$display("%0t: run limit reached", $time);
		$display("selective_repeat_receive_window_core: mismatch");
		$finish;
	end

endmodule

>>> selective_repeat_receive_window_core.f
+incdir+sv
sv/srrw_pkg.sv
sv/srrw_intf.sv
sv/srrw_sub.sv
sv/srrw_out.sv
sv/selective_repeat_receive_window_core.sv
sv/srrw_checker.sv
tb/testbench.sv
